>>> hw/rtl/aa2rm_pkg.sv
// Package for the axis-angle to rotation matrix block.
// Holds the fixed-point formats, the CORDIC arctangent table, the remainder table of
// the angle scaler and the payload structs. It depends on nothing.
package aa2rm_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int VALUE_FRAC_BITS = 15;
  localparam int ANGLE_W = ANGLE_FRAC_BITS + 10;
  localparam int VALUE_W = VALUE_FRAC_BITS + 1;
  localparam int MAG_W = ANGLE_W;

  localparam int CORDIC_STEPS = 31;
  localparam int CORDIC_FRAC = 30;
  localparam int CW = 34;
  localparam int PW = 32;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  // The half angle |a| * 2^31 / (45 * 2^(3+AFB)) is split into a quotient and a
  // remainder of |a| / 45; the remainder part comes from a small table.
  localparam int DIV_K = 45;
  localparam int DIV_SH = 28 - ANGLE_FRAC_BITS;
  localparam int REM_HALF = 22;
  localparam int RK = ANGLE_W + 6;
  localparam int RECIP = ((1 << RK) + DIV_K - 1) / DIV_K;
  localparam int REM_W = 6;
  localparam int REM_N = 1 << REM_W;

  typedef logic [31:0] rem_tab_t [REM_N];

  function automatic rem_tab_t gen_rem_tab();
    rem_tab_t t;
    for (int r = 0; r < REM_N; r++) begin
      if (r < DIV_K) begin
        t[r] = 32'(((64'(r) << DIV_SH) + 64'(REM_HALF)) / 64'(DIV_K));
      end else begin
        t[r] = '0;
      end
    end
    return t;
  endfunction

  localparam rem_tab_t REM_TAB = gen_rem_tab();

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic                      flip;
    logic signed [VALUE_W-1:0] ax;
    logic signed [VALUE_W-1:0] ay;
    logic signed [VALUE_W-1:0] az;
  } side_t;

endpackage

>>> hw/rtl/aa2rm_if.sv
// Valid/ready channel interfaces for the axis-angle to rotation matrix block.
// Depends on aa2rm_pkg for the field widths.
interface aa2rm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [aa2rm_pkg::ANGLE_W-1:0] angle_deg;
  logic signed [aa2rm_pkg::VALUE_W-1:0] axis_x;
  logic signed [aa2rm_pkg::VALUE_W-1:0] axis_y;
  logic signed [aa2rm_pkg::VALUE_W-1:0] axis_z;

  modport source (output valid, angle_deg, axis_x, axis_y, axis_z, input ready);
  modport sink (input valid, angle_deg, axis_x, axis_y, axis_z, output ready);
endinterface

interface aa2rm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [aa2rm_pkg::VALUE_W-1:0] m00;
  logic signed [aa2rm_pkg::VALUE_W-1:0] m01;
  logic signed [aa2rm_pkg::VALUE_W-1:0] m02;
  logic signed [aa2rm_pkg::VALUE_W-1:0] m10;
  logic signed [aa2rm_pkg::VALUE_W-1:0] m11;
  logic signed [aa2rm_pkg::VALUE_W-1:0] m12;
  logic signed [aa2rm_pkg::VALUE_W-1:0] m20;
  logic signed [aa2rm_pkg::VALUE_W-1:0] m21;
  logic signed [aa2rm_pkg::VALUE_W-1:0] m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

>>> hw/rtl/aa2rm_angle_map.sv
// Front end: maps the angle in degrees to a 32-bit binary half angle folded into
// the right half plane, in four stages. Depends on aa2rm_pkg.
module aa2rm_angle_map (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic signed [aa2rm_pkg::ANGLE_W-1:0] in_ang,
  input  aa2rm_pkg::side_t                     in_sd,
  output logic                                 out_vld,
  output aa2rm_pkg::cordic_t                   out_c,
  output aa2rm_pkg::side_t                     out_sd
);

  localparam int MAG_W = aa2rm_pkg::MAG_W;
  localparam int RK = aa2rm_pkg::RK;
  localparam int CW = aa2rm_pkg::CW;

  logic [3:0]                        vld_r;
  aa2rm_pkg::side_t                  sd_r [4];
  logic [2:0]                        neg_r;
  logic [MAG_W-1:0]                  mag1_r, mag2_r, q2_r, q3_r;
  logic [aa2rm_pkg::REM_W-1:0]       rm3_r;
  aa2rm_pkg::cordic_t                c_r;

  logic [MAG_W-1:0]                  mag_nxt, q_nxt;
  logic [MAG_W+RK-1:0]               prod;
  logic [aa2rm_pkg::REM_W-1:0]       rm_nxt;
  logic [31:0]                       pm, p, pt, pf;
  logic                              flip;
  aa2rm_pkg::side_t                  sd3_nxt;

  always_comb begin
    mag_nxt = in_ang[aa2rm_pkg::ANGLE_W-1] ? MAG_W'(-in_ang) : MAG_W'(in_ang);
    prod = (MAG_W+RK)'(mag1_r) * (MAG_W+RK)'(aa2rm_pkg::RECIP);
    q_nxt = MAG_W'(prod >> RK);
    rm_nxt = aa2rm_pkg::REM_W'(mag2_r - MAG_W'(q2_r * MAG_W'(aa2rm_pkg::DIV_K)));
    pm = 32'({q3_r, {aa2rm_pkg::DIV_SH{1'b0}}}) + aa2rm_pkg::REM_TAB[rm3_r];
    p = neg_r[2] ? (32'd0 - pm) : pm;
    pt = p + 32'h4000_0000;
    flip = pt[31];
    pf = flip ? (p + 32'h8000_0000) : p;
    sd3_nxt = sd_r[2];
    sd3_nxt.flip = flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= in_sd;
      sd_r[1] <= sd_r[0];
      sd_r[2] <= sd_r[1];
      sd_r[3] <= sd3_nxt;
      neg_r <= {neg_r[1:0], in_ang[aa2rm_pkg::ANGLE_W-1]};
      mag1_r <= mag_nxt;
      mag2_r <= mag1_r;
      q2_r <= q_nxt;
      q3_r <= q2_r;
      rm3_r <= rm_nxt;
      c_r.x <= aa2rm_pkg::CORDIC_GAIN;
      c_r.y <= '0;
      c_r.z <= CW'(signed'(pf));
    end
  end

  assign out_vld = vld_r[3];
  assign out_c = c_r;
  assign out_sd = sd_r[3];

endmodule

>>> hw/rtl/aa2rm_cordic_cell.sv
// One rotation-mode CORDIC step as a pipeline cell; hands x, y, z and the axis
// to the next cell every cycle in which en is high. Depends on aa2rm_pkg.
module aa2rm_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  aa2rm_pkg::cordic_t in_c,
  input  aa2rm_pkg::side_t   in_sd,
  output logic               out_vld,
  output aa2rm_pkg::cordic_t out_c,
  output aa2rm_pkg::side_t   out_sd
);

  localparam int CW = aa2rm_pkg::CW;

  logic                 vld_r;
  aa2rm_pkg::cordic_t   c_r, c_nxt;
  aa2rm_pkg::side_t     sd_r;
  logic signed [CW-1:0] dx, dy, at;

  always_comb begin
    dx = in_c.x >>> IDX;
    dy = in_c.y >>> IDX;
    at = CW'(aa2rm_pkg::ATAN_TAB[IDX]);
    c_nxt = in_c;
    if (!in_c.z[CW-1]) begin
      c_nxt.x = in_c.x - dy;
      c_nxt.y = in_c.y + dx;
      c_nxt.z = in_c.z - at;
    end else begin
      c_nxt.x = in_c.x + dy;
      c_nxt.y = in_c.y - dx;
      c_nxt.z = in_c.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
      sd_r <= in_sd;
    end
  end

  assign out_vld = vld_r;
  assign out_c = c_r;
  assign out_sd = sd_r;

endmodule

>>> hw/rtl/aa2rm_matrix.sv
// Back end: forms the quaternion from cosine, sine and axis, then the nine matrix
// entries with rounding and saturation, in five stages. Depends on aa2rm_pkg.
module aa2rm_matrix (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  aa2rm_pkg::cordic_t                   in_c,
  input  aa2rm_pkg::side_t                     in_sd,
  output logic                                 out_vld,
  output logic signed [aa2rm_pkg::VALUE_W-1:0] m_out [9]
);

  localparam int CW = aa2rm_pkg::CW;
  localparam int PW = aa2rm_pkg::PW;
  localparam int VW = aa2rm_pkg::VALUE_W;
  localparam int VFB = aa2rm_pkg::VALUE_FRAC_BITS;
  localparam int PA_W = VW + CW;
  localparam int PR_W = 2 * PW;
  localparam int SW = PR_W + 3;
  localparam int FSH = 2 * aa2rm_pkg::CORDIC_FRAC - VFB;
  localparam logic signed [PA_W-1:0] HALF_Q = PA_W'(1) << (VFB - 1);
  localparam logic signed [SW-1:0] ONE = SW'(1) << (2 * aa2rm_pkg::CORDIC_FRAC);
  localparam logic signed [SW-1:0] HALF_F = SW'(1) << (FSH - 1);
  localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (VW - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  logic [4:0]               vld_r;
  logic signed [PW-1:0]     q0a_r;
  logic signed [PA_W-1:0]   pa_r [3];
  logic signed [PW-1:0]     q_r [4];
  logic signed [PR_W-1:0]   pr_r [10];
  logic signed [SW-1:0]     sum_r [9];
  logic signed [VW-1:0]     m_r [9];

  logic signed [CW-1:0]     c, s;
  logic signed [PA_W-1:0]   pa_nxt [3];
  logic signed [PW-1:0]     q_nxt [4];
  logic signed [PR_W-1:0]   pr_nxt [10];
  logic signed [SW-1:0]     e [10];
  logic signed [SW-1:0]     sum_nxt [9];
  logic signed [SW-1:0]     rd [9];
  logic signed [VW-1:0]     m_nxt [9];

  always_comb begin
    c = in_sd.flip ? -in_c.x : in_c.x;
    s = in_sd.flip ? -in_c.y : in_c.y;
    pa_nxt[0] = PA_W'(in_sd.ax) * PA_W'(s);
    pa_nxt[1] = PA_W'(in_sd.ay) * PA_W'(s);
    pa_nxt[2] = PA_W'(in_sd.az) * PA_W'(s);
    q_nxt[0] = q0a_r;
    for (int i = 0; i < 3; i++) begin
      q_nxt[i+1] = PW'((pa_r[i] + HALF_Q) >>> VFB);
    end
    pr_nxt[0] = PR_W'(q_r[0]) * PR_W'(q_r[0]);
    pr_nxt[1] = PR_W'(q_r[1]) * PR_W'(q_r[1]);
    pr_nxt[2] = PR_W'(q_r[2]) * PR_W'(q_r[2]);
    pr_nxt[3] = PR_W'(q_r[3]) * PR_W'(q_r[3]);
    pr_nxt[4] = PR_W'(q_r[1]) * PR_W'(q_r[2]);
    pr_nxt[5] = PR_W'(q_r[0]) * PR_W'(q_r[3]);
    pr_nxt[6] = PR_W'(q_r[1]) * PR_W'(q_r[3]);
    pr_nxt[7] = PR_W'(q_r[0]) * PR_W'(q_r[2]);
    pr_nxt[8] = PR_W'(q_r[2]) * PR_W'(q_r[3]);
    pr_nxt[9] = PR_W'(q_r[0]) * PR_W'(q_r[1]);
    for (int i = 0; i < 10; i++) begin
      e[i] = SW'(pr_r[i]);
    end
    sum_nxt[0] = ((e[0] + e[1]) <<< 1) - ONE;
    sum_nxt[1] = (e[4] - e[5]) <<< 1;
    sum_nxt[2] = (e[6] + e[7]) <<< 1;
    sum_nxt[3] = (e[4] + e[5]) <<< 1;
    sum_nxt[4] = ((e[0] + e[2]) <<< 1) - ONE;
    sum_nxt[5] = (e[8] - e[9]) <<< 1;
    sum_nxt[6] = (e[6] - e[7]) <<< 1;
    sum_nxt[7] = (e[8] + e[9]) <<< 1;
    sum_nxt[8] = ((e[0] + e[3]) <<< 1) - ONE;
    for (int i = 0; i < 9; i++) begin
      rd[i] = (sum_r[i] + HALF_F) >>> FSH;
      if (rd[i] > SAT_HI) begin
        m_nxt[i] = VW'(SAT_HI);
      end else if (rd[i] < SAT_LO) begin
        m_nxt[i] = VW'(SAT_LO);
      end else begin
        m_nxt[i] = VW'(rd[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q0a_r <= PW'(c);
      pa_r <= pa_nxt;
      q_r <= q_nxt;
      pr_r <= pr_nxt;
      sum_r <= sum_nxt;
      m_r <= m_nxt;
    end
  end

  assign out_vld = vld_r[4];
  assign m_out = m_r;

endmodule

>>> hw/rtl/axis_angle_to_rotation_matrix.sv
// Channel     Dir  Payload                               Handshake
// in_chan     in   angle_deg, axis_x, axis_y, axis_z     valid/ready
// out_chan    out  m00 m01 m02 m10 m11 m12 m20 m21 m22   valid/ready
//
// One item enters per cycle while the output is not stalled.
// Each accepted item passes through the four angle stages, the 31 CORDIC cells and the five matrix stages.
// A stalled output freezes the whole pipeline; in_chan.ready is low only then.
// Reset is synchronous and clears the valid bits of every stage.
// Top level; depends on aa2rm_pkg, aa2rm_if, aa2rm_angle_map, aa2rm_cordic_cell, aa2rm_matrix.
module axis_angle_to_rotation_matrix (
  input  logic        clk,
  input  logic        rst_n,
  aa2rm_in_if.sink    in_chan,
  aa2rm_out_if.source out_chan
);

  localparam int STEPS = aa2rm_pkg::CORDIC_STEPS;
  localparam int CW = aa2rm_pkg::CW;
  localparam logic signed [CW-1:0] ZLIM = CW'(32'h4000_0000);

  logic                             en;
  logic [STEPS:0]                   cvld;
  aa2rm_pkg::cordic_t               cdat [STEPS+1];
  aa2rm_pkg::side_t                 csd [STEPS+1];
  aa2rm_pkg::side_t                 in_sd;
  logic signed [aa2rm_pkg::VALUE_W-1:0] m [9];

  assign en = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;

  always_comb begin
    in_sd.flip = 1'b0;
    in_sd.ax = in_chan.axis_x;
    in_sd.ay = in_chan.axis_y;
    in_sd.az = in_chan.axis_z;
  end

  aa2rm_angle_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_chan.valid),
    .in_ang  (in_chan.angle_deg),
    .in_sd   (in_sd),
    .out_vld (cvld[0]),
    .out_c   (cdat[0]),
    .out_sd  (csd[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    aa2rm_cordic_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (cvld[i]),
      .in_c    (cdat[i]),
      .in_sd   (csd[i]),
      .out_vld (cvld[i+1]),
      .out_c   (cdat[i+1]),
      .out_sd  (csd[i+1])
    );
  end

  aa2rm_matrix u_mat (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (cvld[STEPS]),
    .in_c    (cdat[STEPS]),
    .in_sd   (csd[STEPS]),
    .out_vld (out_chan.valid),
    .m_out   (m)
  );

  assign out_chan.m00 = m[0];
  assign out_chan.m01 = m[1];
  assign out_chan.m02 = m[2];
  assign out_chan.m10 = m[3];
  assign out_chan.m11 = m[4];
  assign out_chan.m12 = m[5];
  assign out_chan.m20 = m[6];
  assign out_chan.m21 = m[7];
  assign out_chan.m22 = m[8];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("Result valid after reset.");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(cvld))
    else $error("CORDIC chain moved during a stall.");

  a_half_plane: assert property (@(posedge clk) disable iff (!rst_n)
    cvld[0] |-> (cdat[0].z <= ZLIM && cdat[0].z >= -ZLIM))
    else $error("Folded half angle outside the right half plane.");

endmodule
